/* src/sjfq_pkg.sv */
// Package: sizes, codes, states, item, entry and request types for the queue.
package sjfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned LENGTH_BITS = 8;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OP_W        = 2;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_INSERT,
    S_SHIFT_DN,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]        opcode;
    logic [ID_BITS-1:0]     proc_id;
    logic [LENGTH_BITS-1:0] job_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   head_valid;
    logic [ID_BITS-1:0]     head_id;
    logic [LENGTH_BITS-1:0] applied_length;
    logic [OCC_W-1:0]       occupancy;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [LENGTH_BITS-1:0] len;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

endpackage

/* src/sjfq_store.sv */
// Entry store: one write port, one registered read port.
module sjfq_store (
  input  logic              clk_i,
  input  sjfq_pkg::mem_req_t req_i,
  output sjfq_pkg::entry_t   rdata_o
);

  sjfq_pkg::entry_t mem_q [sjfq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

/* src/sjf_sorted_ready_queue_core.sv */
// Top level: shortest-job-first ready queue with a sequenced entry walk.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_i         | item in
//  out     | out_valid_o, out_ready_i, out_o      | item out
//  cfg     | cfg_we_i, cfg_wdata_i                | write only
//
// One item at a time through one store read port and one write port.
// Enqueue: scan of n entries, shift up of the m entries from the insert point,
// insert, head read, capture; on duplicate or full, no shift and no insert.
// Dequeue: scan, shift down if found, head read, capture. Pick: read, capture.
// Reset empties the queue at once; no clearing pass.
// A stalled result holds the last step; in_ready_o is high only when idle.
module sjf_sorted_ready_queue_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sjfq_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sjfq_pkg::out_item_t  out_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);

  localparam int unsigned AW = sjfq_pkg::ADDR_W;
  localparam int unsigned CW = sjfq_pkg::CNT_W;
  localparam int unsigned LW = sjfq_pkg::LENGTH_BITS;
  localparam int unsigned IW = sjfq_pkg::ID_BITS;

  sjfq_pkg::state_e state_q, state_d;

  logic [LW-1:0]                 dflt_q;
  logic [sjfq_pkg::OP_W-1:0]     op_q, op_d;
  logic [IW-1:0]                 id_q, id_d;
  logic [LW-1:0]                 len_q, len_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 pos_q, pos_d;
  logic [CW-1:0]                 at_q, at_d;
  logic                          found_q, found_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [AW-1:0]                 rd_idx_q, rd_idx_d;
  logic [sjfq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [LW-1:0]                 applied_q, applied_d;
  logic                          out_valid_q, out_valid_d;
  sjfq_pkg::out_item_t           out_q, out_d;

  sjfq_pkg::mem_req_t req;
  sjfq_pkg::entry_t   rdata;

  logic          in_acc;
  logic          scan_done;
  logic          up_done;
  logic          dn_done;
  logic          op_pick;
  logic          enq_ok;
  logic          deq_ok;
  logic [CW-1:0] idx_dec;

  sjfq_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign in_ready_o  = (state_q == sjfq_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign idx_dec   = idx_q - CW'(1);
  assign scan_done = (idx_q == cnt_q) && !rd_vld_q;
  assign up_done   = (idx_q == pos_q) && !rd_vld_q;
  assign dn_done   = (idx_q == cnt_q) && !rd_vld_q;
  assign op_pick   = (in_i.opcode != sjfq_pkg::OP_ENQ) && (in_i.opcode != sjfq_pkg::OP_DEQ);
  assign enq_ok    = (op_q == sjfq_pkg::OP_ENQ) && !found_q &&
                     (cnt_q != CW'(sjfq_pkg::QUEUE_DEPTH));
  assign deq_ok    = (op_q == sjfq_pkg::OP_DEQ) && found_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sjfq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = op_pick ? sjfq_pkg::S_HEAD_RD : sjfq_pkg::S_SCAN;
        end
      end
      sjfq_pkg::S_SCAN: begin
        if (scan_done) begin
          if (enq_ok) begin
            state_d = sjfq_pkg::S_SHIFT_UP;
          end else if (deq_ok) begin
            state_d = sjfq_pkg::S_SHIFT_DN;
          end else begin
            state_d = sjfq_pkg::S_HEAD_RD;
          end
        end
      end
      sjfq_pkg::S_SHIFT_UP: begin
        if (up_done) begin
          state_d = sjfq_pkg::S_INSERT;
        end
      end
      sjfq_pkg::S_INSERT:   state_d = sjfq_pkg::S_HEAD_RD;
      sjfq_pkg::S_SHIFT_DN: begin
        if (dn_done) begin
          state_d = sjfq_pkg::S_HEAD_RD;
        end
      end
      sjfq_pkg::S_HEAD_RD:  state_d = sjfq_pkg::S_HEAD_CAP;
      sjfq_pkg::S_HEAD_CAP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = sjfq_pkg::S_IDLE;
        end
      end
      default: state_d = sjfq_pkg::S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    op_d        = op_q;
    id_d        = id_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    at_d        = at_q;
    found_d     = found_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    status_d    = status_q;
    applied_d   = applied_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    req         = '0;
    req.wdata   = rdata;

    case (state_q)
      sjfq_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d      = in_i.opcode;
          id_d      = in_i.proc_id;
          len_d     = (in_i.job_length == '0) ? dflt_q : in_i.job_length;
          idx_d     = '0;
          pos_d     = '0;
          at_d      = '0;
          found_d   = 1'b0;
          applied_d = '0;
          status_d  = (op_pick && cnt_q == '0) ? sjfq_pkg::ST_EMPTY : sjfq_pkg::ST_OK;
        end
      end
      sjfq_pkg::S_SCAN: begin
        if (idx_q < cnt_q) begin
          req.rd_en = 1'b1;
          req.raddr = idx_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (rdata.id == id_q && !found_q) begin
            found_d = 1'b1;
            at_d    = CW'(rd_idx_q);
          end
          if (rdata.len <= len_q) begin
            pos_d = CW'(rd_idx_q) + CW'(1);
          end
        end
        if (scan_done) begin
          if (op_q == sjfq_pkg::OP_ENQ) begin
            if (found_q) begin
              status_d = sjfq_pkg::ST_DUP;
            end else if (cnt_q == CW'(sjfq_pkg::QUEUE_DEPTH)) begin
              status_d = sjfq_pkg::ST_FULL;
            end
            idx_d = cnt_q;
          end else begin
            if (cnt_q == '0) begin
              status_d = sjfq_pkg::ST_EMPTY;
            end else if (!found_q) begin
              status_d = sjfq_pkg::ST_NOT_FOUND;
            end
            idx_d = at_q + CW'(1);
          end
        end
      end
      sjfq_pkg::S_SHIFT_UP: begin
        if (idx_q > pos_q) begin
          req.rd_en = 1'b1;
          req.raddr = idx_dec[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_dec[AW-1:0];
          idx_d     = idx_dec;
        end
        if (rd_vld_q) begin
          req.we    = 1'b1;
          req.waddr = rd_idx_q + AW'(1);
        end
      end
      sjfq_pkg::S_INSERT: begin
        req.we       = 1'b1;
        req.waddr    = pos_q[AW-1:0];
        req.wdata.id = id_q;
        req.wdata.len = len_q;
        cnt_d        = cnt_q + CW'(1);
        applied_d    = len_q;
      end
      sjfq_pkg::S_SHIFT_DN: begin
        if (idx_q < cnt_q) begin
          req.rd_en = 1'b1;
          req.raddr = idx_q[AW-1:0];
          rd_vld_d  = 1'b1;
          rd_idx_d  = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        if (rd_vld_q) begin
          req.we    = 1'b1;
          req.waddr = rd_idx_q - AW'(1);
        end
        if (dn_done) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      sjfq_pkg::S_HEAD_RD: begin
        req.rd_en = 1'b1;
        req.raddr = '0;
      end
      sjfq_pkg::S_HEAD_CAP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = status_q;
          out_d.head_valid     = (cnt_q != '0);
          out_d.head_id        = (cnt_q != '0) ? rdata.id : '0;
          out_d.applied_length = applied_q;
          out_d.occupancy      = sjfq_pkg::OCC_W'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sjfq_pkg::S_IDLE;
      dflt_q      <= LW'(5);
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    len_q     <= len_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    at_q      <= at_d;
    found_q   <= found_d;
    rd_idx_q  <= rd_idx_d;
    status_q  <= status_d;
    applied_q <= applied_d;
    out_q     <= out_d;
  end

endmodule
